// File: rtl/vfr_pkg.sv
// Shared types and constants for the volume fade ramp controller.
// Holds the payload structs, the state and code enums and the derived widths.
// Depends on nothing; every other file in rtl imports it.
package vfr_pkg;

	// Field widths.
	localparam int STEP_BITS = 16;
	localparam int VOL_W     = 8;
	localparam int PER_W     = 10;
	localparam int DUR_W     = 16;
	localparam int MODE_W    = 2;
	localparam int ACT_W     = 2;

	// Divider and multiplier widths. The widest division is the rescale of a
	// step, (N_old + 1) * N_new / N_old.
	localparam int DVS_W     = (STEP_BITS > PER_W) ? STEP_BITS : PER_W;
	localparam int MUL_A_W   = STEP_BITS + 1;
	localparam int DIV_W     = MUL_A_W + STEP_BITS;
	localparam int CNT_W     = $clog2(DIV_W + 1);
	localparam int CEIL_W    = DUR_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [DIV_W-1:0] STEP_MAX = DIV_W'((64'd1 << STEP_BITS) - 64'd1);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MS_PER_STEP   = 1'b1;

	// Input action codes; the fourth code is unused and changes nothing.
	typedef enum logic [ACT_W-1:0] {
		ACT_TICK     = 2'd0,
		ACT_FADE_OUT = 2'd1,
		ACT_FADE_IN  = 2'd2
	} action_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE = 2'd0,
		MODE_OUT  = 2'd1,
		MODE_IN   = 2'd2
	} mode_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CEIL,
		ST_MUL,
		ST_RESC,
		ST_VOL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [DUR_W-1:0] duration_ms;
		logic             end_pause;
	} in_t;

	typedef struct packed {
		logic [VOL_W-1:0]  volume;
		logic [MODE_W-1:0] fade_mode;
		logic              pause_request;
		logic              stop_request;
		logic              resume_request;
	} out_t;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/vfr_div.sv
// Restoring divider, one quotient bit per cycle, for the fade controller.
// Serves the step count, the step rescale and the volume division.
// Depends on vfr_pkg.
module vfr_div import vfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   shift_c;
	logic             ge_c;
	logic [DVS_W:0]   diff_c;

	// Trial subtraction of the divisor from the partial remainder.
	always_comb begin
		shift_c = {rem_q, quo_q[DIV_W-1]};
		ge_c    = (shift_c >= {1'b0, dvs_q});
		diff_c  = shift_c - {1'b0, dvs_q};
	end

	// Control: busy while bits remain, done for one cycle after the last bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Data: the dividend shifts out of the quotient register as bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge_c};
			rem_q <= ge_c ? diff_c[DVS_W-1:0] : shift_c[DVS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// File: rtl/volume_fade_ramp_controller.sv
// Linear volume fade controller: one input transaction per audio buffer tick or
// fade command, one result transaction for each. A tick outside a fade uses no
// division, a tick during a fade or a fade command from rest divides once, and
// a fade command during a running fade divides twice, all on the single shared
// divider, which produces one quotient bit per cycle over a 33-bit dividend.
// The input stalls while an item is in work. The result sits in an output
// register, so the next item is taken while a result waits. The user must
// write configuration only while no item is in work; the block itself does
// not enforce it.
module volume_fade_ramp_controller import vfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t                 state_q, state_d;
	mode_t                  mode_q, newmode_q;
	logic [STEP_BITS-1:0]   step_q, total_q, nnew_q;
	logic                   pause_q;
	logic [VOL_W-1:0]       master_q;
	logic [PER_W-1:0]       msps_q;
	logic                   tick_q;
	logic [MUL_A_W-1:0]     mul_a_q;
	logic [STEP_BITS-1:0]   mul_b_q;
	logic [DVS_W-1:0]       dvs_q;
	out_t                   res_q;
	out_t                   out_q;
	logic                   out_valid_q;

	logic                   accept;
	logic                   out_free;
	logic                   fading_c;
	logic [PER_W-1:0]       per_eff_c;
	logic [CEIL_W-1:0]      ceil_num_c;
	logic [STEP_BITS-1:0]   s_c;
	logic [STEP_BITS-1:0]   x_c;
	logic [MUL_A_W-1:0]     st_c;
	logic [STEP_BITS-1:0]   n_new_c;
	logic [STEP_BITS-1:0]   resc_c;
	logic [DIV_W-1:0]       prod_c;
	out_t                   res_init_c;

	logic                   div_start;
	logic [DIV_W-1:0]       div_dividend;
	logic [DVS_W-1:0]       div_divisor;
	div_stat_t              div_stat;
	logic [DIV_W-1:0]       div_quo;

	vfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Operand preparation shared by ticks and commands.
	always_comb begin
		fading_c   = (mode_q != MODE_NONE) && (total_q != '0);
		per_eff_c  = (msps_q == '0) ? PER_W'(1) : msps_q;
		ceil_num_c = {1'b0, in_data.duration_ms} + CEIL_W'(per_eff_c) - CEIL_W'(1);
		s_c        = (step_q > total_q) ? total_q : step_q;
		x_c        = (mode_q == MODE_OUT) ? (total_q - s_c) : s_c;
		st_c       = (newmode_q == mode_q) ? {1'b0, s_c}
		                                  : ({1'b0, total_q} - {1'b0, s_c} + MUL_A_W'(1));
		if (div_quo == '0) begin
			n_new_c = STEP_BITS'(1);
		end else if (div_quo > STEP_MAX) begin
			n_new_c = STEP_MAX[STEP_BITS-1:0];
		end else begin
			n_new_c = div_quo[STEP_BITS-1:0];
		end
		resc_c = (div_quo > DIV_W'(nnew_q)) ? nnew_q : div_quo[STEP_BITS-1:0];
		prod_c = mul_a_q * mul_b_q;
	end

	// Result fields that are known when the transaction is accepted.
	always_comb begin
		res_init_c           = '0;
		res_init_c.fade_mode = mode_q;
		case (in_data.action)
			ACT_TICK: begin
				res_init_c.volume = master_q;
				if (!fading_c) begin
					res_init_c.fade_mode = MODE_NONE;
				end else if (s_c >= total_q) begin
					res_init_c.fade_mode     = MODE_NONE;
					res_init_c.pause_request = (mode_q == MODE_OUT) && pause_q;
					res_init_c.stop_request  = (mode_q == MODE_OUT) && !pause_q;
				end
			end
			ACT_FADE_IN: begin
				res_init_c.resume_request = (mode_q == MODE_NONE);
			end
			default: ;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests.
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = DIV_W'(ceil_num_c);
		div_divisor  = DVS_W'(per_eff_c);
		in_stall     = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.action)
						ACT_TICK: begin
							state_d = fading_c ? ST_MUL : ST_DONE;
						end
						ACT_FADE_OUT, ACT_FADE_IN: begin
							div_start = 1'b1;
							state_d   = ST_CEIL;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_CEIL: begin
				if (div_stat.done) begin
					state_d = (mode_q == MODE_NONE || total_q == '0) ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				div_start    = 1'b1;
				div_dividend = prod_c;
				div_divisor  = dvs_q;
				state_d      = tick_q ? ST_VOL : ST_RESC;
			end
			ST_RESC, ST_VOL: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Fade state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			step_q   <= '0;
			total_q  <= '0;
			pause_q  <= 1'b0;
			master_q <= VOL_W'(128);
			msps_q   <= PER_W'(23);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MASTER_VOLUME: master_q <= cfg_data[VOL_W-1:0];
					REG_MS_PER_STEP:   msps_q   <= cfg_data[PER_W-1:0];
					default:           ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.action)
							ACT_TICK: begin
								if (fading_c) begin
									if (s_c < total_q) begin
										step_q <= s_c + STEP_BITS'(1);
									end else begin
										step_q <= total_q;
										mode_q <= MODE_NONE;
									end
								end else begin
									mode_q <= MODE_NONE;
								end
							end
							ACT_FADE_OUT: begin
								pause_q <= in_data.end_pause;
							end
							default: ;
						endcase
					end
				end
				ST_CEIL: begin
					if (div_stat.done && (mode_q == MODE_NONE || total_q == '0)) begin
						step_q  <= '0;
						total_q <= n_new_c;
						mode_q  <= newmode_q;
					end
				end
				ST_RESC: begin
					if (div_stat.done) begin
						step_q  <= resc_c;
						total_q <= nnew_q;
						mode_q  <= newmode_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers and the result under construction.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_q  <= res_init_c;
					tick_q <= (in_data.action == ACT_TICK);
					case (in_data.action)
						ACT_TICK: begin
							mul_a_q <= MUL_A_W'(master_q);
							mul_b_q <= x_c;
							dvs_q   <= DVS_W'(total_q);
						end
						ACT_FADE_OUT: begin
							newmode_q <= MODE_OUT;
						end
						ACT_FADE_IN: begin
							newmode_q <= MODE_IN;
						end
						default: ;
					endcase
				end
			end
			ST_CEIL: begin
				if (div_stat.done) begin
					nnew_q          <= n_new_c;
					mul_a_q         <= st_c;
					mul_b_q         <= n_new_c;
					dvs_q           <= DVS_W'(total_q);
					res_q.fade_mode <= newmode_q;
				end
			end
			ST_VOL: begin
				if (div_stat.done) begin
					res_q.volume <= div_quo[VOL_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The divider is never left running once the sequencer is back at rest.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");

	// The step never runs past the fade length between items.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> step_q <= total_q)
		else $error("step beyond fade length");

	// An active fade always has a nonzero length.
	a_fade_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_NONE |-> total_q != '0)
		else $error("fade active with zero length");

	// A finished fade-out asks for pause or stop, never both, and ends the fade.
	a_end_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.pause_request || out_data.stop_request)
		|-> !(out_data.pause_request && out_data.stop_request)
		    && out_data.fade_mode == MODE_NONE)
		else $error("inconsistent end-of-fade request");

endmodule
